// ----- design/cisata_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the card-information tuple walker.
// No dependencies; used by cisata_walker and the top level.
package cisata_pkg;

  // Item kinds carried on the input tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // Tuple codes and the body bytes that mark the wanted tuples
  localparam logic [7:0] CODE_END     = 8'hff;
  localparam logic [7:0] CODE_FUNCID  = 8'h21;
  localparam logic [7:0] FUNCID_FIXED = 8'h04;
  localparam logic [7:0] CODE_FUNCE   = 8'h22;
  localparam logic [7:0] FUNCE_ATA    = 8'h01;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_CODE = 4'b0010,
    PH_LINK = 4'b0100,
    PH_BODY = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       operation;
    logic [1:0] card_detect;
    logic [7:0] attr_byte;
  } item_t;

  typedef struct packed {
    logic fire;
    logic disk_present;
    logic fixed_disk_seen;
    logic ata_interface_seen;
  } result_t;

endpackage

// ----- design/cisata_walker.sv -----
`timescale 1ns / 1ps
// Tuple walker: scan state registers and the per-item update logic.
// Depends on cisata_pkg for the item, result and phase types.
module cisata_walker #(
  parameter int unsigned SCAN_LIMIT = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  cisata_pkg::item_t   item,
  output cisata_pkg::result_t res
);

  // Tuple start can run past the limit by one header plus a full body
  localparam int unsigned TS_W = $clog2(SCAN_LIMIT + 258);

  cisata_pkg::phase_t phase_r, phase_nxt;
  logic [TS_W-1:0] ts_r, ts_nxt;
  logic [7:0]      rem_r, rem_nxt;
  logic [7:0]      code_r, code_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic            fbm_r, fbm_nxt;
  logic            fixed_r, fixed_nxt;
  logic            ata_r, ata_nxt;
  logic            tuple_done;

  always_comb begin
    phase_nxt  = phase_r;
    ts_nxt     = ts_r;
    rem_nxt    = rem_r;
    code_nxt   = code_r;
    idx_nxt    = idx_r;
    fbm_nxt    = fbm_r;
    fixed_nxt  = fixed_r;
    ata_nxt    = ata_r;
    tuple_done = 1'b0;
    res        = '0;

    if (item.operation == cisata_pkg::OP_START) begin
      ts_nxt    = '0;
      rem_nxt   = '0;
      code_nxt  = '0;
      idx_nxt   = '0;
      fbm_nxt   = 1'b0;
      fixed_nxt = 1'b0;
      ata_nxt   = 1'b0;
      if (item.card_detect != 2'b00) begin
        // no card: report empty at once
        res.fire  = 1'b1;
        phase_nxt = cisata_pkg::PH_IDLE;
      end else begin
        phase_nxt = cisata_pkg::PH_CODE;
      end
    end else begin
      case (phase_r)
        cisata_pkg::PH_CODE: begin
          if (item.attr_byte == cisata_pkg::CODE_END) begin
            res.fire               = 1'b1;
            res.disk_present       = fixed_r & ata_r;
            res.fixed_disk_seen    = fixed_r;
            res.ata_interface_seen = ata_r;
            phase_nxt              = cisata_pkg::PH_IDLE;
          end else begin
            code_nxt  = item.attr_byte;
            phase_nxt = cisata_pkg::PH_LINK;
          end
        end
        cisata_pkg::PH_LINK: begin
          rem_nxt = item.attr_byte;
          idx_nxt = '0;
          fbm_nxt = 1'b0;
          ts_nxt  = ts_r + TS_W'(2) + TS_W'(item.attr_byte);
          if (item.attr_byte == 8'd0) begin
            tuple_done = 1'b1;
          end else begin
            phase_nxt = cisata_pkg::PH_BODY;
          end
        end
        cisata_pkg::PH_BODY: begin
          if (idx_r == 2'd0) begin
            if (code_r == cisata_pkg::CODE_FUNCID && item.attr_byte == cisata_pkg::FUNCID_FIXED)
              fixed_nxt = 1'b1;
            else if (code_r == cisata_pkg::CODE_FUNCE && item.attr_byte == cisata_pkg::FUNCE_ATA)
              fbm_nxt = 1'b1;
          end else if (idx_r == 2'd1) begin
            if (code_r == cisata_pkg::CODE_FUNCE && fbm_r
                && item.attr_byte == cisata_pkg::FUNCE_ATA)
              ata_nxt = 1'b1;
          end
          if (idx_r != 2'd2) idx_nxt = idx_r + 2'd1;
          rem_nxt = rem_r - 8'd1;
          if (rem_r == 8'd1) tuple_done = 1'b1;
        end
        default: begin
          // byte while idle: drop
        end
      endcase

      // End of tuple: finish if both seen or the next tuple is out of range
      if (tuple_done) begin
        if ((fixed_nxt && ata_nxt) || (ts_nxt >= TS_W'(SCAN_LIMIT))) begin
          res.fire               = 1'b1;
          res.disk_present       = fixed_nxt & ata_nxt;
          res.fixed_disk_seen    = fixed_nxt;
          res.ata_interface_seen = ata_nxt;
          phase_nxt              = cisata_pkg::PH_IDLE;
        end else begin
          phase_nxt = cisata_pkg::PH_CODE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cisata_pkg::PH_IDLE;
      ts_r    <= '0;
      rem_r   <= '0;
      code_r  <= '0;
      idx_r   <= '0;
      fbm_r   <= 1'b0;
      fixed_r <= 1'b0;
      ata_r   <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      ts_r    <= ts_nxt;
      rem_r   <= rem_nxt;
      code_r  <= code_nxt;
      idx_r   <= idx_nxt;
      fbm_r   <= fbm_nxt;
      fixed_r <= fixed_nxt;
      ata_r   <= ata_nxt;
    end
  end

endmodule

// ----- design/cis_tuple_ata_card_detector_unit.sv -----
`timescale 1ns / 1ps
// ATA card detector: a start item samples the card-detect pins, then
// card-information bytes stream in one per cycle and the tuple walker looks
// for the fixed-disk and ATA-interface tuples. Each transfer is registered,
// processed by the walker from the input register and, if it ends the scan,
// its result is registered in the output register. One item is taken every
// cycle; input stalls only when a scan-ending item meets a full output
// register that is not being drained. Depends on cisata_pkg and
// cisata_walker.
module cis_tuple_ata_card_detector_unit #(
  parameter int unsigned SCAN_LIMIT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] card_detect, [9:2] attr_byte, [15:10] zero
  input  logic [0:0]  in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] disk_present, [1] fixed_disk_seen,
                                  // [2] ata_interface_seen, [7:3] zero
);

  logic                s1_valid_r;
  cisata_pkg::item_t   s1_item_r;
  cisata_pkg::result_t res;
  logic                out_free;
  logic                s1_go;
  logic                s1_fire;
  logic                out_valid_r;
  logic [2:0]          out_data_r;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = !res.fire || out_free;
  assign s1_fire   = s1_valid_r && s1_go;
  assign in_tready = !s1_valid_r || s1_go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.operation   <= in_tuser[0];
      s1_item_r.card_detect <= in_tdata[1:0];
      s1_item_r.attr_byte   <= in_tdata[9:2];
    end
  end

  cisata_walker #(
    .SCAN_LIMIT(SCAN_LIMIT)
  ) u_walker (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(s1_fire),
    .item   (s1_item_r),
    .res    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && res.fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res.fire) begin
      out_data_r <= {res.ata_interface_seen, res.fixed_disk_seen, res.disk_present};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_data_r};

  a_disk_needs_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[0] || (out_tdata[1] && out_tdata[2])))
    else $error("disk_present without both tuples");

  a_no_card_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_item_r.operation == cisata_pkg::OP_START
     && s1_item_r.card_detect != 2'b00)
    |-> (res.fire && !res.disk_present && !res.fixed_disk_seen && !res.ata_interface_seen))
    else $error("start without card must report empty");

  a_card_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_item_r.operation == cisata_pkg::OP_START
     && s1_item_r.card_detect == 2'b00) |-> !res.fire)
    else $error("start with card must not report");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && res.fire && out_valid_r && !out_tready))
    else $error("input stalled without a blocked result");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for cis_tuple_ata_card_detector_unit: directed table, a hold-off fill, random
// scans under changing sender idle and receiver stall, then a scan-limit run. Depends on cisata_pkg and the RTL.
module testbench;

  localparam int unsigned SCAN_LIMIT  = 256;
  localparam int unsigned RAND_ITEMS  = 140;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 10;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned NUM_ROWS    = 24;

  typedef struct packed {
    logic ata;
    logic fixed;
    logic disk;
  } scan_result_t;

  typedef struct packed {
    bit           typed;
    bit           has_res;
    scan_result_t res;
  } result_tag_t;

  typedef struct packed {
    logic         op;
    logic [1:0]   cd;
    logic [7:0]   cis;
    bit           typed;
    bit           has_res;
    scan_result_t res;
  } stim_row_t;

  localparam result_tag_t UNTYPED = '{typed: 1'b0, has_res: 1'b0, res: 3'b000};

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // [1:0] card_detect, [9:2] attr_byte, [15:10] zero
  logic [0:0]  in_tuser   = '0;   // [0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [0] disk_present, [1] fixed_disk_seen,
                                  // [2] ata_interface_seen, [7:3] zero

  cis_tuple_ata_card_detector_unit #(.SCAN_LIMIT(SCAN_LIMIT)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Tuple walker state
  cisata_pkg::phase_t walk_phase = cisata_pkg::PH_IDLE;
  logic [9:0]  walk_tuple_start = '0;
  logic [7:0]  walk_body_left   = '0;
  logic [7:0]  walk_code        = '0;
  logic [1:0]  walk_body_idx    = '0;
  logic        walk_first_match = 1'b0;
  logic        walk_fixed       = 1'b0;
  logic        walk_ata         = 1'b0;

  scan_result_t scan_results_due[$];
  result_tag_t  pending_tags[$];
  stim_row_t    directed_rows[NUM_ROWS];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned holds_served   = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;
  int unsigned error_count    = 0;
  int unsigned useful_items   = 0;
  int unsigned results_seen   = 0;
  int unsigned disks_seen     = 0;

  function automatic bit walk_cis_item(input logic op, input logic [1:0] cd,
                                       input logic [7:0] cis, output scan_result_t res);
    bit   done;
    bit   tuple_over;
    logic plugged;
    done       = 1'b0;
    tuple_over = 1'b0;
    plugged    = 1'b1;
    res        = '0;
    if (op == cisata_pkg::OP_START) begin
      walk_tuple_start = '0;
      walk_body_left   = '0;
      walk_code        = '0;
      walk_body_idx    = '0;
      walk_first_match = 1'b0;
      walk_fixed       = 1'b0;
      walk_ata         = 1'b0;
      if (cd != 2'b00) begin
        done    = 1'b1;
        plugged = 1'b0;
      end else begin
        walk_phase = cisata_pkg::PH_CODE;
      end
    end else begin
      case (walk_phase)
        cisata_pkg::PH_CODE: begin
          if (cis == cisata_pkg::CODE_END) begin
            done = 1'b1;
          end else begin
            walk_code  = cis;
            walk_phase = cisata_pkg::PH_LINK;
          end
        end
        cisata_pkg::PH_LINK: begin
          walk_body_left   = cis;
          walk_body_idx    = '0;
          walk_first_match = 1'b0;
          walk_tuple_start = walk_tuple_start + 10'd2 + {2'b00, cis};
          if (cis == 8'd0) tuple_over = 1'b1;
          else walk_phase = cisata_pkg::PH_BODY;
        end
        cisata_pkg::PH_BODY: begin
          if (walk_body_idx == 2'd0) begin
            if (walk_code == cisata_pkg::CODE_FUNCID && cis == cisata_pkg::FUNCID_FIXED)
              walk_fixed = 1'b1;
            else if (walk_code == cisata_pkg::CODE_FUNCE && cis == cisata_pkg::FUNCE_ATA)
              walk_first_match = 1'b1;
          end else if (walk_body_idx == 2'd1) begin
            if (walk_code == cisata_pkg::CODE_FUNCE && walk_first_match
                && cis == cisata_pkg::FUNCE_ATA)
              walk_ata = 1'b1;
          end
          if (walk_body_idx < 2'd2) walk_body_idx = walk_body_idx + 2'd1;
          if (walk_body_left > 8'd0) walk_body_left = walk_body_left - 8'd1;
          if (walk_body_left == 8'd0) tuple_over = 1'b1;
        end
        default: ;
      endcase
      if (tuple_over) begin
        if ((walk_fixed && walk_ata) || walk_tuple_start >= SCAN_LIMIT) done = 1'b1;
        else walk_phase = cisata_pkg::PH_CODE;
      end
    end
    if (done) begin
      res.disk   = plugged & walk_fixed & walk_ata;
      res.fixed  = plugged & walk_fixed;
      res.ata    = plugged & walk_ata;
      walk_phase = cisata_pkg::PH_IDLE;
    end
    return done;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Offer one item, with a random idle gap ahead of it, and hold until transfer
  task automatic send_item(input logic op, input logic [1:0] cd, input logic [7:0] cis,
                           input result_tag_t tag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    pending_tags.push_back(tag);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b000000, cis, cd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_cis(input logic [7:0] cis);
    send_item(cisata_pkg::OP_BYTE, 2'($urandom_range(3)), cis, UNTYPED);
  endtask

  // One scan: mostly well-formed tuples with random content, sometimes cut short; else noise or a no-card start
  task automatic random_scan();
    int unsigned ntup;
    int unsigned pick;
    logic [7:0]  code;
    logic [7:0]  link;
    logic [7:0]  cis;
    pick = $urandom_range(9);
    if (pick == 0) begin
      // noise: unstructured items
      repeat ($urandom_range(1, 8))
        send_item(1'($urandom_range(1)), 2'($urandom_range(3)), 8'($urandom_range(255)),
                  UNTYPED);
      return;
    end
    if (pick == 1) begin
      send_item(cisata_pkg::OP_START, 2'($urandom_range(1, 3)), 8'($urandom_range(255)),
                UNTYPED);
      return;
    end
    send_item(cisata_pkg::OP_START, 2'b00, 8'($urandom_range(255)), UNTYPED);
    ntup = $urandom_range(1, 6);
    for (int t = 0; t < ntup; t++) begin
      pick = $urandom_range(9);
      if (pick < 3) code = cisata_pkg::CODE_FUNCID;
      else if (pick < 6) code = cisata_pkg::CODE_FUNCE;
      else if (pick == 6) code = cisata_pkg::CODE_END;
      else code = 8'($urandom_range(255));
      send_cis(code);
      if (code == cisata_pkg::CODE_END) return;
      if ($urandom_range(63) == 0) return;
      link = ($urandom_range(39) == 0) ? 8'($urandom_range(8, 40)) : 8'($urandom_range(4));
      send_cis(link);
      for (int i = 0; i < link; i++) begin
        cis = 8'($urandom_range(255));
        if (code == cisata_pkg::CODE_FUNCID && i == 0 && $urandom_range(3) != 0)
          cis = cisata_pkg::FUNCID_FIXED;
        if (code == cisata_pkg::CODE_FUNCE && i < 2 && $urandom_range(3) != 0)
          cis = cisata_pkg::FUNCE_ATA;
        if ($urandom_range(63) == 0) return;
        send_cis(cis);
      end
    end
    if ($urandom_range(1) == 0) send_cis(cisata_pkg::CODE_END);
  endtask

  // Long first tuple to reach the end of the scan window
  task automatic limit_scan(input logic [7:0] link);
    send_item(cisata_pkg::OP_START, 2'b00, 8'h00, UNTYPED);
    send_cis(8'($urandom_range(254)));
    send_cis(link);
    for (int i = 0; i < link; i++) send_cis(8'($urandom_range(255)));
    send_cis(8'($urandom_range(254)));
    send_cis(8'h00);
  endtask

  // Predict each input transfer in order
  always @(posedge clk) begin
    bit           fired;
    scan_result_t res;
    result_tag_t  tag;
    if (rst_n && in_tvalid && in_tready) begin
      tag = pending_tags.pop_front();
      if (!(in_tuser[0] == cisata_pkg::OP_BYTE && walk_phase == cisata_pkg::PH_IDLE))
        useful_items++;
      fired = walk_cis_item(in_tuser[0], in_tdata[1:0], in_tdata[9:2], res);
      if (tag.typed) begin
        if (tag.has_res) scan_results_due.push_back(tag.res);
      end else if (fired) begin
        scan_results_due.push_back(res);
      end
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    scan_result_t want;
    scan_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[2:0];
      if (scan_results_due.size() == 0) begin
        report_mismatch($sformatf("result %b with nothing expected", got));
      end else begin
        want = scan_results_due.pop_front();
        if (got.disk !== want.disk)
          report_mismatch($sformatf("disk_present %b, want %b", got.disk, want.disk));
        if (got.fixed !== want.fixed)
          report_mismatch($sformatf("fixed_disk_seen %b, want %b", got.fixed, want.fixed));
        if (got.ata !== want.ata)
          report_mismatch($sformatf("ata_interface_seen %b, want %b", got.ata, want.ata));
        results_seen++;
        if (want.disk) disks_seen++;
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_tready   <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               scan_results_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    result_tag_t tag;
    int unsigned rand_base;
    directed_rows = '{
      '{cisata_pkg::OP_BYTE,  2'd2, 8'h55, 1'b1, 1'b0, 3'b000},  // byte while idle: dropped
      '{cisata_pkg::OP_START, 2'd1, 8'h00, 1'b1, 1'b1, 3'b000},  // no card
      '{cisata_pkg::OP_START, 2'd2, 8'hff, 1'b1, 1'b1, 3'b000},
      '{cisata_pkg::OP_START, 2'd3, 8'h00, 1'b1, 1'b1, 3'b000},
      '{cisata_pkg::OP_START, 2'd0, 8'h00, 1'b1, 1'b0, 3'b000},
      '{cisata_pkg::OP_BYTE,  2'd0, 8'hff, 1'b1, 1'b1, 3'b000},  // end code first
      '{cisata_pkg::OP_START, 2'd0, 8'h00, 1'b0, 1'b0, 3'b000},
      '{cisata_pkg::OP_BYTE,  2'd3, 8'h21, 1'b0, 1'b0, 3'b000},
      '{cisata_pkg::OP_BYTE,  2'd0, 8'h01, 1'b0, 1'b0, 3'b000},
      '{cisata_pkg::OP_BYTE,  2'd0, 8'h04, 1'b0, 1'b0, 3'b000},
      '{cisata_pkg::OP_BYTE,  2'd0, 8'h22, 1'b0, 1'b0, 3'b000},
      '{cisata_pkg::OP_BYTE,  2'd0, 8'h02, 1'b0, 1'b0, 3'b000},
      '{cisata_pkg::OP_BYTE,  2'd0, 8'h01, 1'b0, 1'b0, 3'b000},
      '{cisata_pkg::OP_BYTE,  2'd0, 8'h01, 1'b0, 1'b0, 3'b000},  // both tuples found
      '{cisata_pkg::OP_START, 2'd0, 8'h00, 1'b0, 1'b0, 3'b000},
      '{cisata_pkg::OP_BYTE,  2'd0, 8'h21, 1'b0, 1'b0, 3'b000},
      '{cisata_pkg::OP_BYTE,  2'd0, 8'h00, 1'b0, 1'b0, 3'b000},  // empty body
      '{cisata_pkg::OP_BYTE,  2'd0, 8'h22, 1'b0, 1'b0, 3'b000},
      '{cisata_pkg::OP_BYTE,  2'd0, 8'h01, 1'b0, 1'b0, 3'b000},  // short tuple
      '{cisata_pkg::OP_BYTE,  2'd0, 8'h01, 1'b0, 1'b0, 3'b000},
      '{cisata_pkg::OP_BYTE,  2'd0, 8'h01, 1'b0, 1'b0, 3'b000},
      '{cisata_pkg::OP_BYTE,  2'd1, 8'h00, 1'b0, 1'b0, 3'b000},
      '{cisata_pkg::OP_START, 2'd0, 8'h00, 1'b0, 1'b0, 3'b000},  // restart mid-scan
      '{cisata_pkg::OP_BYTE,  2'd0, 8'hff, 1'b0, 1'b0, 3'b000}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      tag = '{typed: directed_rows[i].typed, has_res: directed_rows[i].has_res,
              res: directed_rows[i].res};
      send_item(directed_rows[i].op, directed_rows[i].cd, directed_rows[i].cis, tag);
    end

    // Fill the block while the receiver holds off
    hold_requests = hold_requests + 1;
    repeat (6) begin
      send_item(cisata_pkg::OP_START, 2'($urandom_range(1, 3)), 8'h00, UNTYPED);
      random_scan();
    end

    rand_base = useful_items;
    while (useful_items - rand_base < RAND_ITEMS) begin
      case (((useful_items - rand_base) * 4) / RAND_ITEMS)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      random_scan();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 38;
    limit_scan(8'd254);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (scan_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d start and byte transfers through the tuple walker", useful_items);
    $display("Checked %0d scan results, %0d with a disk present", results_seen, disks_seen);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
